// ----- rtl/yti_pkg.sv -----
// ----------------------------------------------------------------------------
// yti_pkg
// Shared types, constants and helpers of the YUYV to I420 converter.
// ----------------------------------------------------------------------------
package yti_pkg;

	// Configuration port
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_REG_W  = 12;

	// Register index, taken from paddr[2]
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic [CFG_REG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
	localparam logic [CFG_REG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

	// Defaults for the top level parameters
	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_HEIGHT = 2048;

	// Decoupling queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Position fields in flight; bounded by the 12-bit size registers
	// (row < 4094, column < 2047) whatever the parameters are.
	localparam int ROW_BITS = 12;
	localparam int COL_BITS = 11;

	typedef struct packed {
		logic [7:0] luma_a;
		logic [7:0] chroma_u;
		logic [7:0] luma_b;
		logic [7:0] chroma_v;
	} yuyv_t;

	typedef struct packed {
		logic [21:0] luma_address;
		logic [7:0]  luma_first;
		logic [7:0]  luma_second;
		logic        chroma_valid;
		logic [19:0] chroma_index;
		logic [7:0]  cb_out;
		logic [7:0]  cr_out;
		logic        frame_end;
	} plane_t;

	// Classified macropixel, front to back
	typedef struct packed {
		yuyv_t              pix;
		logic [7:0]         prev_cb;
		logic [7:0]         prev_cr;
		logic [ROW_BITS-1:0] row;
		logic [COL_BITS-1:0] col;
		logic               odd;
		logic [19:0]        chroma_index;
		logic               frame_end;
	} item_t;

	// Register value with low bit cleared, kept within [2, maxv & ~1]
	function automatic logic [CFG_REG_W-1:0] eff_size(input logic [CFG_REG_W-1:0] r,
		input int maxv);
		int s;
		s = int'(r & 12'hFFE);
		if (s == 0) begin
			s = 2;
		end
		if (s > maxv) begin
			s = maxv & ~1;
		end
		if (s == 0) begin
			s = 2;
		end
		return CFG_REG_W'(s);
	endfunction

endpackage

// ----- rtl/yti_queue.sv -----
// ----------------------------------------------------------------------------
// yti_queue
// Small register FIFO that decouples the front and back of the converter.
// ----------------------------------------------------------------------------
module yti_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign dout  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/yti_front.sv -----
// ----------------------------------------------------------------------------
// yti_front
// Accepts macropixels, tracks raster position, keeps the chroma line store.
// ----------------------------------------------------------------------------
module yti_front #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          yuyv_valid,
	output logic                          yuyv_stall,
	input  yti_pkg::yuyv_t                yuyv,
	input  logic [yti_pkg::CFG_REG_W-1:0] w_eff,
	input  logic [yti_pkg::CFG_REG_W-1:0] h_eff,
	output logic                          item_valid,
	output yti_pkg::item_t                item,
	input  logic                          item_full
);
	import yti_pkg::*;

	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int COL_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int ROW_W      = $clog2(MAX_HEIGHT);

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [19:0]      cidx_q;

	logic [15:0]      line_mem [LINE_DEPTH];
	logic [15:0]      rd_q;

	logic                valid_s1;
	yuyv_t               pix_s1;
	logic [ROW_BITS-1:0] row_s1;
	logic [COL_BITS-1:0] col_s1;
	logic                odd_s1;
	logic [19:0]         cidx_s1;
	logic                fend_s1;

	logic        accept;
	logic        odd;
	logic [11:0] col_inc;
	logic [12:0] row_inc;
	logic        row_end;
	logic        frame_end;

	assign yuyv_stall = valid_s1 && item_full;
	assign accept     = yuyv_valid && !yuyv_stall;

	assign odd       = row_q[0];
	assign col_inc   = 12'(col_q) + 12'd1;
	assign row_inc   = 13'(row_q) + 13'd1;
	assign row_end   = (col_inc >= {1'b0, w_eff[11:1]});
	assign frame_end = row_end && (row_inc >= {1'b0, h_eff});

	// Raster position and chroma index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			cidx_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				col_q  <= '0;
				row_q  <= '0;
				cidx_q <= '0;
			end else begin
				if (row_end) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
				if (odd) begin
					cidx_q <= cidx_q + 20'd1;
				end
			end
		end
	end

	// Line store: even rows write, odd rows read one row later
	always_ff @(posedge clk) begin
		if (accept && !odd) begin
			line_mem[col_q] <= {yuyv.chroma_u, yuyv.chroma_v};
		end
	end

	always_ff @(posedge clk) begin
		if (accept && odd) begin
			rd_q <= line_mem[col_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!item_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= yuyv;
			row_s1  <= ROW_BITS'(row_q);
			col_s1  <= COL_BITS'(col_q);
			odd_s1  <= odd;
			cidx_s1 <= cidx_q;
			fend_s1 <= frame_end;
		end
	end

	assign item_valid = valid_s1;

	always_comb begin
		item.pix          = pix_s1;
		item.prev_cb      = rd_q[15:8];
		item.prev_cr      = rd_q[7:0];
		item.row          = row_s1;
		item.col          = col_s1;
		item.odd          = odd_s1;
		item.chroma_index = cidx_s1;
		item.frame_end    = fend_s1;
	end

endmodule

// ----- rtl/yti_back.sv -----
// ----------------------------------------------------------------------------
// yti_back
// Computes plane addresses and chroma averages and holds the output register.
// ----------------------------------------------------------------------------
module yti_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [yti_pkg::CFG_REG_W-1:0] w_eff,
	input  yti_pkg::item_t                item,
	input  logic                          item_empty,
	output logic                          item_pop,
	output logic                          plane_valid,
	input  logic                          plane_stall,
	output yti_pkg::plane_t               plane
);
	import yti_pkg::*;

	logic                valid_s2;
	logic [21:0]         prod_s2;
	logic [COL_BITS-1:0] col_s2;
	logic [7:0]          la_s2, lb_s2;
	logic                odd_s2;
	logic [19:0]         cidx_s2;
	logic [7:0]          cb_s2, cr_s2;
	logic                fend_s2;

	logic   valid_q;
	plane_t plane_q;

	logic       out_adv, s2_adv;
	logic [8:0] cb_sum, cr_sum;

	assign out_adv  = !valid_q || !plane_stall;
	assign s2_adv   = !valid_s2 || out_adv;
	assign item_pop = !item_empty && s2_adv;

	// rounded vertical average
	assign cb_sum = 9'(item.prev_cb) + 9'(item.pix.chroma_u) + 9'd1;
	assign cr_sum = 9'(item.prev_cr) + 9'(item.pix.chroma_v) + 9'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (s2_adv) begin
				valid_s2 <= item_pop;
			end
			if (out_adv) begin
				valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			prod_s2 <= 22'(item.row) * 22'(w_eff);
			col_s2  <= item.col;
			la_s2   <= item.pix.luma_a;
			lb_s2   <= item.pix.luma_b;
			odd_s2  <= item.odd;
			cidx_s2 <= item.chroma_index;
			cb_s2   <= cb_sum[8:1];
			cr_s2   <= cr_sum[8:1];
			fend_s2 <= item.frame_end;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s2) begin
			plane_q.luma_address <= prod_s2 + 22'({col_s2, 1'b0});
			plane_q.luma_first   <= la_s2;
			plane_q.luma_second  <= lb_s2;
			plane_q.chroma_valid <= odd_s2;
			plane_q.chroma_index <= odd_s2 ? cidx_s2 : '0;
			plane_q.cb_out       <= odd_s2 ? cb_s2 : '0;
			plane_q.cr_out       <= odd_s2 ? cr_s2 : '0;
			plane_q.frame_end    <= fend_s2;
		end
	end

	assign plane_valid = valid_q;
	assign plane       = plane_q;

endmodule

// ----- rtl/yuyv_to_i420_converter_unit.sv -----
// ----------------------------------------------------------------------------
// yuyv_to_i420_converter_unit
// Packed YUYV 4:2:2 stream in, planar I420 luma and chroma writes out.
// ----------------------------------------------------------------------------
// One macropixel (Y0 U Y1 V) per transaction on the yuyv channel, raster order.
// Each produces exactly one transaction on the plane channel: both luma samples
// with their luma-plane address row*width + 2*col, and on odd rows the Cb/Cr
// pair averaged with the row above, (a+b+1)>>1, plus its chroma-plane index;
// on even rows the chroma fields are zero and U/V go into the line store. The
// last macropixel of a frame carries frame_end. Throughput is one macropixel
// per clock, sustained while the plane side does not stall; each result passes
// the line store read, queue, address multiply stage and output register. The
// four-entry queue lets input and output stall independently. Write frame_width
// (addr 0x0) and frame_height (addr 0x4) only while the block is idle; the low
// bit is ignored and sizes are clamped to [2, MAX_*]. An odd row column that no
// even row wrote returns undefined chroma.
// ----------------------------------------------------------------------------
module yuyv_to_i420_converter_unit #(
	parameter int MAX_WIDTH  = yti_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = yti_pkg::DEF_MAX_HEIGHT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [yti_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [yti_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [yti_pkg::CFG_DATA_W-1:0] prdata,
	output logic                           pready,
	// macropixel stream
	input  logic                           yuyv_valid,
	output logic                           yuyv_stall,
	input  yti_pkg::yuyv_t                 yuyv,
	// plane writes
	output logic                           plane_valid,
	input  logic                           plane_stall,
	output yti_pkg::plane_t                plane
);
	import yti_pkg::*;

	logic [CFG_REG_W-1:0] width_q, height_q;
	logic [CFG_REG_W-1:0] w_eff, h_eff;
	logic                 cfg_wr;

	logic  item_valid, item_full, item_empty, item_pop;
	item_t item_in, item_out;

	// --- configuration registers ------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= FRAME_WIDTH_RST;
			height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_FRAME_WIDTH:  width_q  <= pwdata[CFG_REG_W-1:0];
				REG_FRAME_HEIGHT: height_q <= pwdata[CFG_REG_W-1:0];
				default:          width_q  <= width_q;
			endcase
		end
	end

	// low address bits do not decode
	assign prdata = CFG_DATA_W'((paddr[2] == REG_FRAME_HEIGHT) ? height_q : width_q);

	// Effective frame size; the user keeps it static while items are in flight, the block does not enforce this
	assign w_eff = eff_size(width_q, MAX_WIDTH);
	assign h_eff = eff_size(height_q, MAX_HEIGHT);

	// --- front: accept, position, line store ------------------------------
	yti_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.yuyv_valid (yuyv_valid),
		.yuyv_stall (yuyv_stall),
		.yuyv       (yuyv),
		.w_eff      (w_eff),
		.h_eff      (h_eff),
		.item_valid (item_valid),
		.item       (item_in),
		.item_full  (item_full)
	);

	// --- decoupling queue -------------------------------------------------
	yti_queue #(
		.WIDTH ($bits(item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (item_valid && !item_full),
		.din    (item_in),
		.full   (item_full),
		.pop    (item_pop),
		.dout   (item_out),
		.empty  (item_empty)
	);

	// --- back: address, averaging, output register ------------------------
	yti_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.w_eff       (w_eff),
		.item        (item_out),
		.item_empty  (item_empty),
		.item_pop    (item_pop),
		.plane_valid (plane_valid),
		.plane_stall (plane_stall),
		.plane       (plane)
	);

endmodule

// ----- rtl/yti_checker.sv -----
// ----------------------------------------------------------------------------
// yti_checker
// Port-level checks on the converter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module yti_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            yuyv_valid,
	input logic            yuyv_stall,
	input logic            plane_valid,
	input logic            plane_stall,
	input yti_pkg::plane_t plane
);
	import yti_pkg::*;

	logic       in_acc, out_acc;
	logic [3:0] pend_q;
	logic       frame_start_q;

	assign in_acc  = yuyv_valid && !yuyv_stall;
	assign out_acc = plane_valid && !plane_stall;

	// transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({in_acc, out_acc})
				2'b10:   pend_q <= pend_q + 4'd1;
				2'b01:   pend_q <= pend_q - 4'd1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	// next result opens a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_start_q <= 1'b1;
		end else if (out_acc) begin
			frame_start_q <= plane.frame_end;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		plane_valid && plane_stall |=> plane_valid && $stable(plane))
		else $error("stalled plane transaction changed");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		plane_valid |-> pend_q != 4'd0)
		else $error("plane transaction without accepted macropixel");

	a_even_row_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !plane.chroma_valid |->
			plane.cb_out == 8'd0 && plane.cr_out == 8'd0 && plane.chroma_index == 20'd0)
		else $error("chroma fields set on even row");

	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && frame_start_q |->
			plane.luma_address == 22'd0 && !plane.chroma_valid)
		else $error("frame does not start at origin");

endmodule

bind yuyv_to_i420_converter_unit yti_checker u_yti_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.yuyv_valid  (yuyv_valid),
	.yuyv_stall  (yuyv_stall),
	.plane_valid (plane_valid),
	.plane_stall (plane_stall),
	.plane       (plane)
);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the YUYV 4:2:2 to I420 converter.
// ----------------------------------------------------------------------------
// A scripted opening walks extremes, odd-row averaging, and size changes
// mid-row and mid-frame. Random phases of macropixels follow, mostly on small
// frames and a few on the largest. Each accepted macropixel runs through an
// in-bench model of the converter, and each plane write is compared with the
// oldest pending prediction. The size registers are rewritten between phases
// with the block drained. Both channels idle at random, and once the plane
// side holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb;
	import yti_pkg::*;

	localparam int MAX_W           = DEF_MAX_WIDTH;
	localparam int MAX_H           = DEF_MAX_HEIGHT;
	localparam int LINE_DEPTH      = MAX_W / 2;
	localparam int RANDOM_ITEMS    = 1428;
	localparam int PRESSURE_PHASE  = 4;
	localparam int HOLD_OFF_CYCLES = 64;
	localparam int SETTLE_CYCLES   = 8;     // settling margin after the drain
	localparam int WATCHDOG_LIMIT  = 1000;

	// Scripted transaction; expected fields apply only when typed is set
	typedef struct {
		bit          reprogram;
		logic [11:0] width;
		logic [11:0] height;
		logic [31:0] pix;
		bit          typed;
		int          addr;
		bit          cvalid;
		int          cindex;
		logic [7:0]  cb;
		logic [7:0]  cr;
		bit          fend;
	} script_row_t;

	typedef struct {
		bit     typed;
		plane_t want;
	} offer_note_t;

	logic   clk         = 1'b0;
	logic   arst_n      = 1'b0;
	logic   psel        = 1'b0;
	logic   penable     = 1'b0;
	logic   pwrite      = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr  = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic   pready;
	logic   yuyv_valid  = 1'b0;
	logic   yuyv_stall;
	yuyv_t  yuyv        = '0;
	logic   plane_valid;
	logic   plane_stall = 1'b0;
	plane_t plane;

	yuyv_to_i420_converter_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.yuyv_valid  (yuyv_valid),
		.yuyv_stall  (yuyv_stall),
		.yuyv        (yuyv),
		.plane_valid (plane_valid),
		.plane_stall (plane_stall),
		.plane       (plane)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	wire pixel_take = yuyv_valid && !yuyv_stall;
	wire plane_take = plane_valid && !plane_stall;
	wire cfg_take   = psel && penable && pready;

	// ------------------------------------------------------------------
	// Converter model state: size registers, raster position, running
	// chroma index and the line store of the last even row.
	// ------------------------------------------------------------------
	logic [11:0] width_reg    = FRAME_WIDTH_RST;
	logic [11:0] height_reg   = FRAME_HEIGHT_RST;
	logic [9:0]  pos_col      = '0;
	logic [10:0] pos_row      = '0;
	logic [19:0] chroma_count = '0;
	logic [7:0]  cb_line [LINE_DEPTH];
	logic [7:0]  cr_line [LINE_DEPTH];
	bit          line_written [LINE_DEPTH];   // entries some even row has filled

	offer_note_t offered_q[$];        // driven, not yet accepted
	plane_t      plane_expect_q[$];   // accepted, write not yet seen

	int  errors       = 0;
	int  n_pixels     = 0;
	int  n_checked    = 0;
	int  n_chroma     = 0;
	int  n_frames     = 0;
	int  n_programs   = 0;
	bit  sender_quiet = 1'b0;
	bit  sink_quiet   = 1'b0;
	bit  hold_off_req = 1'b0;

	// Register value to usable size: low bit dropped, kept in [2, limit]
	function automatic int unsigned effective_dim(logic [11:0] r, int unsigned limit);
		int unsigned s;
		s = r & 12'hFFE;
		if (s == 0) begin
			s = 2;
		end
		if (s > limit) begin
			s = limit & ~32'd1;
		end
		if (s == 0) begin
			s = 2;
		end
		return s;
	endfunction

	// One macropixel through the converter; advances the raster position
	function automatic plane_t convert_macropixel(yuyv_t px);
		plane_t      r;
		int unsigned w, h, hw, col, row, pb, pr;
		bit          row_end, last;
		w       = effective_dim(width_reg, MAX_W);
		h       = effective_dim(height_reg, MAX_H);
		hw      = w / 2;
		col     = pos_col;
		row     = pos_row;
		row_end = (col + 1) >= hw;
		last    = row_end && (row + 1) >= h;
		r = '0;
		r.luma_address = 22'(row * w + 2 * col);
		r.luma_first   = px.luma_a;
		r.luma_second  = px.luma_b;
		if (pos_row[0]) begin
			// odd row: average with the row above, round half up
			pb = (col < LINE_DEPTH) ? cb_line[col] : 0;
			pr = (col < LINE_DEPTH) ? cr_line[col] : 0;
			r.chroma_valid = 1'b1;
			r.chroma_index = chroma_count;
			r.cb_out       = 8'((pb + px.chroma_u + 1) >> 1);
			r.cr_out       = 8'((pr + px.chroma_v + 1) >> 1);
			chroma_count   = chroma_count + 20'd1;
		end else if (col < LINE_DEPTH) begin
			cb_line[col]      = px.chroma_u;
			cr_line[col]      = px.chroma_v;
			line_written[col] = 1'b1;
		end
		r.frame_end = last;
		if (last) begin
			pos_col      = '0;
			pos_row      = '0;
			chroma_count = '0;
		end else if (row_end) begin
			pos_col = '0;
			pos_row = 11'(row + 1);
		end else begin
			pos_col = 10'(col + 1);
		end
		return r;
	endfunction

	// A width change is safe unless the rest of the current odd row would
	// read line store entries never filled
	function automatic bit odd_row_covered(logic [11:0] wreg);
		int unsigned hw, stop, c;
		hw = effective_dim(wreg, MAX_W) / 2;
		if (!pos_row[0]) begin
			return 1'b1;
		end
		stop = (hw > pos_col + 1) ? hw - 1 : pos_col;
		for (c = pos_col; c <= stop; c++) begin
			if (c < LINE_DEPTH && !line_written[c]) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// Mostly small sizes, now and then an extreme or any 12-bit value
	function automatic logic [11:0] draw_dim(int unsigned small_max);
		case ($urandom_range(0, 9))
			0: return 12'($urandom);
			1: begin
				case ($urandom_range(0, 5))
					0: return 12'd0;
					1: return 12'd1;
					2: return 12'd2048;
					3: return 12'd2049;
					4: return 12'd4094;
					default: return 12'd4095;
				endcase
			end
			default: return 12'($urandom_range(0, small_max));
		endcase
	endfunction

	task automatic check_field(string name, longint unsigned want, longint unsigned got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// ------------------------------------------------------------------
	// APB access: setup cycle, then access until pready. Leaves the bus
	// selected so back-to-back accesses need no idle cycle.
	// ------------------------------------------------------------------
	task automatic apb_access(bit wr, logic idx, logic [31:0] data, output logic [31:0] rd);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
	endtask

	// Write both size registers, read them back, release the bus
	task automatic program_size(logic [11:0] w, logic [11:0] h);
		logic [31:0] rd;
		apb_access(1'b1, REG_FRAME_WIDTH, 32'(w), rd);
		width_reg = w;
		apb_access(1'b1, REG_FRAME_HEIGHT, 32'(h), rd);
		height_reg = h;
		apb_access(1'b0, REG_FRAME_WIDTH, '0, rd);
		check_field("frame_width readback", 32'(w), rd);
		apb_access(1'b0, REG_FRAME_HEIGHT, '0, rd);
		check_field("frame_height readback", 32'(h), rd);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		n_programs++;
	endtask

	// Offer one macropixel after a random gap; returns at its acceptance
	task automatic offer_pixel(yuyv_t px, bit typed, plane_t want);
		int          gap;
		offer_note_t note;
		gap = sender_quiet ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			yuyv_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		note.typed = typed;
		note.want  = want;
		offered_q.push_back(note);
		yuyv       <= px;
		yuyv_valid <= 1'b1;
		do @(posedge clk); while (yuyv_stall);
		n_pixels++;
	endtask

	// Stop offering and wait for every predicted write to come out
	task automatic drain();
		yuyv_valid <= 1'b0;
		while (offered_q.size() != 0 || plane_expect_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// ------------------------------------------------------------------
	// Scripted opening. Reset size 640x480 first (even row, chroma zero),
	// then shrink to 4x2 mid-row so the next item ends the row, an odd
	// row averaging against stored extremes, 2x2 frames of one item per
	// row, the largest size, and shrinks of width and height mid-frame.
	// ------------------------------------------------------------------
	script_row_t script [22] = '{
		'{0, 12'd0,   12'd0,   32'h00000000, 1, 0, 0, 0, 8'h00, 8'h00, 0},
		'{0, 12'd0,   12'd0,   32'hFFFFFFFF, 1, 2, 0, 0, 8'h00, 8'h00, 0},
		'{0, 12'd0,   12'd0,   32'hAA5555AA, 1, 4, 0, 0, 8'h00, 8'h00, 0},
		'{0, 12'd0,   12'd0,   32'h55AAAA55, 1, 6, 0, 0, 8'h00, 8'h00, 0},
		'{1, 12'd5,   12'd3,   32'h01808001, 1, 8, 0, 0, 8'h00, 8'h00, 0},
		'{0, 12'd0,   12'd0,   32'h12FF34FF, 1, 4, 1, 0, 8'h80, 8'h80, 0},
		'{0, 12'd0,   12'd0,   32'hFE01EF00, 1, 6, 1, 1, 8'h80, 8'h80, 1},
		'{1, 12'd0,   12'd1,   32'h7FFF80FF, 1, 0, 0, 0, 8'h00, 8'h00, 0},
		'{0, 12'd0,   12'd0,   32'h80FF7FFF, 1, 2, 1, 0, 8'hFF, 8'hFF, 1},
		'{0, 12'd0,   12'd0,   32'h01000100, 1, 0, 0, 0, 8'h00, 8'h00, 0},
		'{0, 12'd0,   12'd0,   32'hFE00FE00, 1, 2, 1, 0, 8'h00, 8'h00, 1},
		'{1, 12'hFFF, 12'hFFF, 32'h01234567, 1, 0, 0, 0, 8'h00, 8'h00, 0},
		'{0, 12'd0,   12'd0,   32'h89ABCDEF, 1, 2, 0, 0, 8'h00, 8'h00, 0},
		'{0, 12'd0,   12'd0,   32'hFEDCBA98, 0, 0, 0, 0, 8'h00, 8'h00, 0},
		'{0, 12'd0,   12'd0,   32'h76543210, 0, 0, 0, 0, 8'h00, 8'h00, 0},
		'{1, 12'd6,   12'hFFF, 32'h3C3CC3C3, 0, 0, 0, 0, 8'h00, 8'h00, 0},
		'{0, 12'd0,   12'd0,   32'hC3C33C3C, 0, 0, 0, 0, 8'h00, 8'h00, 0},
		'{0, 12'd0,   12'd0,   32'h0F0FF0F0, 0, 0, 0, 0, 8'h00, 8'h00, 0},
		'{0, 12'd0,   12'd0,   32'hF0F00F0F, 0, 0, 0, 0, 8'h00, 8'h00, 0},
		'{1, 12'd6,   12'd2,   32'h5A5AA5A5, 0, 0, 0, 0, 8'h00, 8'h00, 0},
		'{0, 12'd0,   12'd0,   32'hA5A55A5A, 0, 0, 0, 0, 8'h00, 8'h00, 0},
		'{0, 12'd0,   12'd0,   32'h7E81817E, 0, 0, 0, 0, 8'h00, 8'h00, 1}
	};

	// ------------------------------------------------------------------
	// Input side: every accepted transaction goes through the model; a
	// scripted row with typed values overrides the model's answer.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : pixel_predict
		plane_t      want;
		offer_note_t note;
		if (arst_n && pixel_take) begin
			want = convert_macropixel(yuyv);
			note = offered_q.pop_front();
			if (note.typed) begin
				want = note.want;
			end
			plane_expect_q.push_back(want);
		end
	end

	// ------------------------------------------------------------------
	// Output side: each plane write against the oldest prediction.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : plane_check
		plane_t want;
		if (arst_n && plane_take) begin
			if (plane_expect_q.size() == 0) begin
				$error("plane write with nothing pending: %h", plane);
				errors++;
			end else begin
				want = plane_expect_q.pop_front();
				check_field("luma_address", want.luma_address, plane.luma_address);
				check_field("luma_first",   want.luma_first,   plane.luma_first);
				check_field("luma_second",  want.luma_second,  plane.luma_second);
				check_field("chroma_valid", want.chroma_valid, plane.chroma_valid);
				check_field("chroma_index", want.chroma_index, plane.chroma_index);
				check_field("cb_out",       want.cb_out,       plane.cb_out);
				check_field("cr_out",       want.cr_out,       plane.cr_out);
				check_field("frame_end",    want.frame_end,    plane.frame_end);
				n_checked++;
				n_chroma += want.chroma_valid;
				n_frames += want.frame_end;
			end
		end
	end

	// ------------------------------------------------------------------
	// Plane sink: random stall before each write, none in quiet phases,
	// and one long hold-off on request so the queue fills and the block
	// pushes back on the yuyv side.
	// ------------------------------------------------------------------
	initial begin : plane_sink
		int hold;
		forever begin
			if (hold_off_req) begin
				hold         = HOLD_OFF_CYCLES;
				hold_off_req = 1'b0;
			end else begin
				hold = sink_quiet ? 0 : $urandom_range(0, 3);
			end
			if (hold > 0) begin
				plane_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			plane_stall <= 1'b0;
			do @(posedge clk); while (!plane_valid);
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: too long with no transaction on any port means a hang.
	// ------------------------------------------------------------------
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || pixel_take || plane_take || cfg_take) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("tb: errors");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		plane_t      want;
		yuyv_t       px;
		logic [11:0] nw, cand;
		int          phase, len, random_items, t;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// scripted part
		foreach (script[i]) begin
			if (script[i].reprogram) begin
				drain();
				program_size(script[i].width, script[i].height);
			end
			px   = yuyv_t'(script[i].pix);
			want = '0;
			want.luma_address = 22'(script[i].addr);
			want.luma_first   = px.luma_a;
			want.luma_second  = px.luma_b;
			want.chroma_valid = script[i].cvalid;
			want.chroma_index = 20'(script[i].cindex);
			want.cb_out       = script[i].cb;
			want.cr_out       = script[i].cr;
			want.frame_end    = script[i].fend;
			offer_pixel(px, script[i].typed, want);
		end

		// random phases; boundaries land anywhere in a row or frame, so
		// size changes hit mid-row and mid-frame positions as well
		phase        = 0;
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			drain();
			if (phase == 0 || $urandom_range(0, 1) == 1) begin
				nw = width_reg;
				for (t = 0; t < 8; t++) begin
					cand = draw_dim(40);
					if (odd_row_covered(cand)) begin
						nw = cand;
						break;
					end
				end
				program_size(nw, draw_dim(12));
			end
			sender_quiet = ($urandom_range(0, 3) == 0);
			sink_quiet   = ($urandom_range(0, 3) == 0);
			len          = $urandom_range(1, 90);
			if (phase == PRESSURE_PHASE) begin
				// back-to-back offers against a held-off sink
				hold_off_req = 1'b1;
				sender_quiet = 1'b1;
				len          = 40;
			end
			// last phase stops at the item budget
			if (len > RANDOM_ITEMS - random_items) begin
				len = RANDOM_ITEMS - random_items;
			end
			repeat (len) begin
				offer_pixel(yuyv_t'($urandom), 1'b0, '0);
				random_items++;
			end
			phase++;
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("summary: %0d macropixels, %0d plane writes checked, %0d with chroma",
			n_pixels, n_checked, n_chroma);
		$display("summary: %0d frames closed, %0d size settings, %0d random phases",
			n_frames, n_programs, phase);
		if (errors == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
